// ===== sv/wabi_pkg.sv =====
package wabi_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_SAMPLES_DEF = 65536;

    localparam int FIELD_W     = 16;
    localparam int LEVEL_W     = 2;
    localparam int COUNT_W     = 17;
    localparam int SUM_W       = 32;
    localparam int INTEG_W     = 33;
    localparam int EPOCH_BITS  = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_W       = 72;

    localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;

    localparam logic [FIELD_W-1:0] CLIP_THRESHOLD_RST  = 16'd512;
    localparam logic [FIELD_W-1:0] WINDOW_LOW_RST      = 16'd10000;
    localparam logic [FIELD_W-1:0] WINDOW_HIGH_RST     = 16'd50000;
    localparam logic [FIELD_W-1:0] INTEGRATE_START_RST = 16'd0;
    localparam logic [LEVEL_W-1:0] START_LEVEL_RST     = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLIP_THRESHOLD  = 3'd0,
        CFG_WINDOW_LOW      = 3'd1,
        CFG_WINDOW_HIGH     = 3'd2,
        CFG_INTEGRATE_START = 3'd3,
        CFG_START_LEVEL     = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        OUT_MEASURED     = 2'd0,
        OUT_RETRY        = 2'd1,
        OUT_UNMEASURABLE = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_RUN,
        BK_WRAP
    } t_back_state;

    // one classified sample as it travels from front to back
    typedef struct packed {
        logic [FIELD_W-1:0] sample;
        logic               first;
        logic               last;
        logic               well;
        logic               hist_en;
        logic               clip;
        logic               sum_en;
    } t_item;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [COUNT_W-1:0]    count;
    } t_hist_word;

    // end-of-waveform totals handed to the result pipeline
    typedef struct packed {
        t_outcome           outcome;
        logic [LEVEL_W-1:0] level_used;
        logic [LEVEL_W-1:0] next_level;
        logic [FIELD_W-1:0] mode_value;
        logic [COUNT_W-1:0] mode_count;
        logic [COUNT_W-1:0] sum_count;
        logic [SUM_W-1:0]   sum;
    } t_raw;

endpackage

// ===== sv/wabi_ram.sv =====
module wabi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wabi_front.sv =====
module wabi_front import wabi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [FIELD_W-1:0]     s_axis_tdata,   // [15:0] sample
    input  logic                   s_axis_tlast,
    input  logic [1:0]             s_axis_tuser,   // [0] first_sample, [1] new_well
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]     i_cfg_data,
    input  logic                   i_init_done,
    input  logic                   i_push_ready,
    output logic                   o_push_valid,
    output t_item                  o_push_item,
    output logic [LEVEL_W-1:0]     o_start_level
);

    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_SAMPLES);

    logic [FIELD_W-1:0] r_clip_threshold;
    logic [FIELD_W-1:0] r_window_low;
    logic [FIELD_W-1:0] r_window_high;
    logic [FIELD_W-1:0] r_integrate_start;
    logic [LEVEL_W-1:0] r_start_level;

    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] smp;
    logic               active;
    logic               from_start;
    logic               push;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_threshold  <= CLIP_THRESHOLD_RST;
            r_window_low      <= WINDOW_LOW_RST;
            r_window_high     <= WINDOW_HIGH_RST;
            r_integrate_start <= INTEGRATE_START_RST;
            r_start_level     <= START_LEVEL_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CLIP_THRESHOLD:  r_clip_threshold  <= i_cfg_data;
                CFG_WINDOW_LOW:      r_window_low      <= i_cfg_data;
                CFG_WINDOW_HIGH:     r_window_high     <= i_cfg_data;
                CFG_INTEGRATE_START: r_integrate_start <= i_cfg_data;
                CFG_START_LEVEL:     r_start_level     <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = i_push_ready && i_init_done;
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        smp        = FIELD_W'(s_axis_tdata[SAMPLE_BITS-1:0]);
        idx        = s_axis_tuser[0] ? '0 : r_idx;
        active     = idx < IDX_LIMIT;
        from_start = CMP_W'(idx) >= CMP_W'(r_integrate_start);
        n_idx      = r_idx;
        if (push && active) begin
            n_idx = idx + IDX_W'(1);
        end else if (push) begin
            n_idx = idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    always_comb begin
        o_push_item.sample  = smp;
        o_push_item.first   = s_axis_tuser[0];
        o_push_item.last    = s_axis_tlast;
        o_push_item.well    = s_axis_tuser[1];
        o_push_item.hist_en = active && (smp >= r_window_low) && (smp < r_window_high);
        o_push_item.clip    = active && (smp < r_clip_threshold);
        o_push_item.sum_en  = active && from_start;
    end

    assign o_push_valid  = push;
    assign o_start_level = r_start_level;

endmodule

// ===== sv/wabi_queue.sv =====
module wabi_queue import wabi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_item            r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_FULL;
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_slot[r_rd];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_item;
        end
    end

endmodule

// ===== sv/wabi_back.sv =====
module wabi_back import wabi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  t_item              i_pop_item,
    input  logic [LEVEL_W-1:0] i_start_level,
    output logic               o_init_done,
    output logic               o_raw_valid,
    input  logic               i_raw_ready,
    output t_raw               o_raw
);

    localparam int ADDR_W = SAMPLE_BITS;
    localparam int DEPTH  = 1 << SAMPLE_BITS;
    localparam int WORD_W = $bits(t_hist_word);

    t_back_state r_state;
    t_back_state n_state;

    logic                  r_b_v;
    t_item                 r_b;
    logic [EPOCH_BITS-1:0] r_epoch;
    logic                  r_post_clear;
    logic                  r_fwd_v;
    logic [ADDR_W-1:0]     r_fwd_addr;
    t_hist_word            r_fwd_word;
    logic [ADDR_W-1:0]     r_sweep_addr;
    logic [LEVEL_W-1:0]    r_power;
    logic [COUNT_W-1:0]    r_best_count;
    logic [FIELD_W-1:0]    r_best_value;
    logic                  r_clipped;
    logic [SUM_W-1:0]      r_sum;
    logic [COUNT_W-1:0]    r_cnt;

    logic                  sweep_en;
    logic                  sweep_last;
    logic                  run;
    logic                  need_wrap;
    logic                  a_go;
    logic                  b_go;
    logic [ADDR_W-1:0]     b_addr;
    logic [EPOCH_BITS-1:0] epoch_eff;
    t_hist_word            rd_word;
    t_hist_word            word;
    t_hist_word            wr_word;
    logic [WORD_W-1:0]     ram_rdata;
    logic [COUNT_W-1:0]    old_count;
    logic [COUNT_W-1:0]    new_count;
    logic [COUNT_W-1:0]    best_c_base;
    logic [FIELD_W-1:0]    best_v_base;
    logic                  clip_base;
    logic [SUM_W-1:0]      sum_base;
    logic [COUNT_W-1:0]    cnt_base;
    logic [LEVEL_W-1:0]    power_base;
    logic                  take;
    logic [COUNT_W-1:0]    best_c;
    logic [FIELD_W-1:0]    best_v;
    logic                  clipped;
    logic [SUM_W-1:0]      sum;
    logic [COUNT_W-1:0]    cnt;
    logic [LEVEL_W-1:0]    power_end;
    logic [LEVEL_W-1:0]    n_power;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_INIT: if (sweep_last) n_state = BK_RUN;
            BK_RUN:  if (need_wrap)  n_state = BK_WRAP;
            BK_WRAP: if (sweep_last) n_state = BK_RUN;
            default: n_state = BK_INIT;
        endcase
    end

    // state outputs
    always_comb begin
        sweep_en    = 1'b0;
        o_init_done = 1'b1;
        run         = 1'b0;
        case (r_state)
            BK_INIT: begin
                sweep_en    = 1'b1;
                o_init_done = 1'b0;
            end
            BK_RUN:  run = 1'b1;
            BK_WRAP: sweep_en = 1'b1;
            default: ;
        endcase
    end

    assign sweep_last = sweep_en && (&r_sweep_addr);

    // a new waveform at the last epoch mark waits for a full clear of the histogram
    assign need_wrap   = r_b_v && r_b.first && (r_epoch == EPOCH_LAST);
    assign b_go        = r_b_v && run && !need_wrap && (!r_b.last || i_raw_ready);
    assign o_pop_ready = run && (!r_b_v || b_go);
    assign a_go        = i_pop_valid && o_pop_ready;
    assign o_raw_valid = r_b_v && run && !need_wrap && r_b.last;

    assign b_addr    = r_b.sample[ADDR_W-1:0];
    assign epoch_eff = r_b.first ? r_epoch + EPOCH_BITS'(1) : r_epoch;
    assign rd_word   = t_hist_word'(ram_rdata);

    always_comb begin
        // the word written as this read was registered is not in the read data
        word = (r_fwd_v && (r_fwd_addr == b_addr)) ? r_fwd_word : rd_word;
        old_count = (r_post_clear || (word.epoch != epoch_eff)) ? '0 : word.count;
        new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_W'(1);

        best_c_base = r_b.first ? '0 : r_best_count;
        best_v_base = r_b.first ? '0 : r_best_value;
        clip_base   = r_b.first ? 1'b0 : r_clipped;
        sum_base    = r_b.first ? '0 : r_sum;
        cnt_base    = r_b.first ? '0 : r_cnt;
        power_base  = (r_b.first && r_b.well) ? i_start_level : r_power;

        take    = r_b.hist_en && (new_count > best_c_base);
        best_c  = take ? new_count : best_c_base;
        best_v  = take ? r_b.sample : best_v_base;
        clipped = clip_base || r_b.clip;
        sum     = sum_base + (r_b.sum_en ? SUM_W'(r_b.sample) : '0);
        cnt     = cnt_base + COUNT_W'(r_b.sum_en);

        wr_word.epoch = epoch_eff;
        wr_word.count = new_count;

        o_raw.level_used = power_base;
        if (clipped) begin
            o_raw.mode_value = '0;
            o_raw.mode_count = '0;
            o_raw.sum_count  = '0;
            o_raw.sum        = '0;
            if (power_base == '0) begin
                o_raw.outcome    = OUT_UNMEASURABLE;
                o_raw.next_level = i_start_level;
                power_end        = power_base;
            end else begin
                o_raw.outcome    = OUT_RETRY;
                o_raw.next_level = power_base - LEVEL_W'(1);
                power_end        = power_base - LEVEL_W'(1);
            end
        end else begin
            o_raw.outcome    = OUT_MEASURED;
            o_raw.next_level = i_start_level;
            o_raw.mode_value = best_v;
            o_raw.mode_count = best_c;
            o_raw.sum_count  = cnt;
            o_raw.sum        = sum;
            power_end        = power_base;
        end
        n_power = r_b.last ? power_end : power_base;
    end

    always_comb begin
        ram_we    = b_go && r_b.hist_en;
        ram_waddr = b_addr;
        ram_wdata = WORD_W'(wr_word);
        if (sweep_en) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = '0;
        end
    end

    wabi_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (a_go),
        .i_raddr (i_pop_item.sample[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_INIT;
            r_b_v        <= 1'b0;
            r_epoch      <= '0;
            r_post_clear <= 1'b0;
            r_fwd_v      <= 1'b0;
            r_sweep_addr <= '0;
            r_power      <= START_LEVEL_RST;
            r_best_count <= '0;
            r_best_value <= '0;
            r_clipped    <= 1'b0;
            r_sum        <= '0;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            if (sweep_en) begin
                r_sweep_addr <= r_sweep_addr + ADDR_W'(1);
                r_fwd_v      <= 1'b0;
            end
            if (sweep_last && (r_state == BK_INIT)) begin
                r_epoch <= EPOCH_BITS'(1);
            end
            if (sweep_last && (r_state == BK_WRAP)) begin
                r_epoch      <= '0;
                r_post_clear <= 1'b1;
            end
            if (a_go) begin
                r_b_v <= 1'b1;
            end else if (b_go) begin
                r_b_v <= 1'b0;
            end
            if (b_go) begin
                r_post_clear <= 1'b0;
                r_epoch      <= epoch_eff;
                r_power      <= n_power;
                r_best_count <= best_c;
                r_best_value <= best_v;
                r_clipped    <= clipped;
                r_sum        <= sum;
                r_cnt        <= cnt;
                if (r_b.hist_en) begin
                    r_fwd_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b <= i_pop_item;
        end
        if (b_go && r_b.hist_en) begin
            r_fwd_addr <= b_addr;
            r_fwd_word <= wr_word;
        end
    end

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && !r_post_clear) |-> (r_epoch != '0))
        else $error("epoch mark zero while histogram is live");

    a_mode_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_count == '0) |-> (r_best_value == '0))
        else $error("mode value set without a count");

    a_wrap_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == BK_WRAP) && run) |-> (r_post_clear && (r_epoch == '0)))
        else $error("wrap pass ended without resetting the epoch mark");

    a_post_clear_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_post_clear |-> r_b_v)
        else $error("cleared-read flag without a held sample");

endmodule

// ===== sv/wabi_result.sv =====
module wabi_result import wabi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_raw_valid,
    output logic             o_raw_ready,
    input  t_raw             i_raw,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int PROD_W = COUNT_W + FIELD_W;

    typedef struct packed {
        t_outcome           outcome;
        logic [LEVEL_W-1:0] level_used;
        logic [LEVEL_W-1:0] next_level;
        logic [FIELD_W-1:0] mode_value;
        logic [COUNT_W-1:0] mode_count;
        logic [SUM_W-1:0]   sum;
        logic [PROD_W-1:0]  prod;
    } t_prod;

    logic               r_s1_v;
    t_raw               r_s1;
    logic               r_s2_v;
    t_prod              r_s2;
    logic               r_out_v;
    logic [OUT_W-1:0]   r_out;

    logic               out_free;
    logic               s2_go;
    logic               s2_free;
    logic               s1_go;
    logic               s1_free;
    logic [INTEG_W-1:0] integral;

    assign out_free    = !r_out_v || m_axis_tready;
    assign s2_go       = r_s2_v && out_free;
    assign s2_free     = !r_s2_v || s2_go;
    assign s1_go       = r_s1_v && s2_free;
    assign s1_free     = !r_s1_v || s1_go;
    assign o_raw_ready = s1_free;

    assign integral = INTEG_W'(r_s2.sum) - INTEG_W'(r_s2.prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_free) r_s1_v <= i_raw_valid;
            if (s2_free) r_s2_v <= r_s1_v;
            if (out_free) r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_raw_valid && s1_free) begin
            r_s1 <= i_raw;
        end
        if (s1_go) begin
            r_s2.outcome    <= r_s1.outcome;
            r_s2.level_used <= r_s1.level_used;
            r_s2.next_level <= r_s1.next_level;
            r_s2.mode_value <= r_s1.mode_value;
            r_s2.mode_count <= r_s1.mode_count;
            r_s2.sum        <= r_s1.sum;
            r_s2.prod       <= PROD_W'(r_s1.sum_count) * PROD_W'(r_s1.mode_value);
        end
        if (s2_go) begin
            r_out <= {integral, r_s2.mode_count, r_s2.mode_value,
                      r_s2.next_level, r_s2.level_used, r_s2.outcome};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

endmodule

// ===== sv/waveform_autorange_baseline_integrator_unit.sv =====
// The last sample passes the queue and r_b; its totals pass r_s1, r_s2 and r_out.
// Throughput: one sample per cycle unless stalled, set by the histogram RAM's one
// read port and one write port, one-deep write forwarding; one result per waveform.
// Reset: a clearing pass over all 2**SAMPLE_BITS words, s_axis_tready low meanwhile.
// The same pass runs before the first sample of every 255th waveform when the
// 8-bit epoch mark wraps; samples queue up and then stall during it.
module waveform_autorange_baseline_integrator_unit import wabi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [FIELD_W-1:0]     s_axis_tdata,   // [15:0] sample
    input  logic                   s_axis_tlast,   // last_sample
    input  logic [1:0]             s_axis_tuser,   // [0] first_sample, [1] new_well
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] outcome, [3:2] level_used, [5:4] next_level, [21:6] mode_value,
    // [38:22] mode_count, [71:39] integral
    output logic [OUT_W-1:0]       m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]     i_cfg_data
);

    logic               init_done;
    logic               push_valid;
    logic               push_ready;
    t_item              push_item;
    logic               pop_valid;
    logic               pop_ready;
    t_item              pop_item;
    logic [LEVEL_W-1:0] start_level;
    logic               raw_valid;
    logic               raw_ready;
    t_raw               raw;

    wabi_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_init_done   (init_done),
        .i_push_ready  (push_ready),
        .o_push_valid  (push_valid),
        .o_push_item   (push_item),
        .o_start_level (start_level)
    );

    wabi_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    wabi_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_item    (pop_item),
        .i_start_level (start_level),
        .o_init_done   (init_done),
        .o_raw_valid   (raw_valid),
        .i_raw_ready   (raw_ready),
        .o_raw         (raw)
    );

    wabi_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_raw_valid   (raw_valid),
        .o_raw_ready   (raw_ready),
        .i_raw         (raw),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== tb/sv/waveform_result_checker.sv =====
`timescale 1ns / 100ps

module waveform_result_checker import wabi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    input  logic [FIELD_W-1:0]     i_s_axis_tdata,   // [15:0] sample
    input  logic                   i_s_axis_tlast,   // last_sample
    input  logic [1:0]             i_s_axis_tuser,   // [0] first_sample, [1] new_well
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [1:0] outcome, [3:2] level_used, [5:4] next_level, [21:6] mode_value,
    // [38:22] mode_count, [71:39] integral
    input  logic [OUT_W-1:0]       i_m_axis_tdata,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]     i_cfg_data,
    output int                     o_failures,
    output int                     o_pending,
    output int                     o_samples,
    output int                     o_results,
    output int                     o_retries,
    output int                     o_unmeasurable
);

    typedef struct packed {
        logic signed [INTEG_W-1:0] integral;
        logic [COUNT_W-1:0]        mode_count;
        logic [FIELD_W-1:0]        mode_value;
        logic [LEVEL_W-1:0]        next_level;
        logic [LEVEL_W-1:0]        level_used;
        t_outcome                  outcome;
    } t_waveform_result;

    t_waveform_result expected_results[$];

    logic [FIELD_W-1:0] clip_threshold;
    logic [FIELD_W-1:0] window_low;
    logic [FIELD_W-1:0] window_high;
    logic [FIELD_W-1:0] integrate_start;
    logic [LEVEL_W-1:0] start_level;

    logic [LEVEL_W-1:0] power_level;
    logic [COUNT_W-1:0] bin_hits [logic [FIELD_W-1:0]];
    logic [COUNT_W-1:0] best_count;
    logic [FIELD_W-1:0] best_value;
    logic [COUNT_W-1:0] sample_index;
    logic               clipped_seen;
    logic [SUM_W-1:0]   window_sum;
    logic [COUNT_W-1:0] window_count;

    task automatic report_mismatch(input string what, input longint seen, input longint wanted);
        // keep the log short on a badly broken block, but count everything
        if (o_failures < 50)
            $display("%0t: result %0d %s: got %0d, expected %0d",
                     $realtime, o_results, what, seen, wanted);
        o_failures++;
    endtask

    task automatic clear_waveform();
        bin_hits.delete();
        best_count   = '0;
        best_value   = '0;
        sample_index = '0;
        clipped_seen = 1'b0;
        window_sum   = '0;
        window_count = '0;
    endtask

    task automatic absorb_sample(input logic [FIELD_W-1:0] smp, input logic first,
                                 input logic last, input logic well);
        logic [COUNT_W-1:0] hits;
        logic [INTEG_W-1:0] scaled;
        t_waveform_result   res;
        if (first) begin
            clear_waveform();
            if (well)
                power_level = start_level;
        end
        // samples past the frame limit add nothing to clipping, histogram or sum
        if (sample_index < MAX_SAMPLES_DEF) begin
            if (smp < clip_threshold)
                clipped_seen = 1'b1;
            if (smp >= window_low && smp < window_high) begin
                hits = bin_hits.exists(smp) ? bin_hits[smp] : '0;
                if (hits != COUNT_MAX)
                    hits++;
                bin_hits[smp] = hits;
                // strictly greater: the first bin to reach a count keeps the mode
                if (hits > best_count) begin
                    best_count = hits;
                    best_value = smp;
                end
            end
            if (sample_index >= integrate_start) begin
                window_sum   += smp;
                window_count += 1'b1;
            end
            sample_index += 1'b1;
        end
        if (last) begin
            res = '0;
            res.level_used = power_level;
            if (clipped_seen) begin
                if (power_level == '0) begin
                    res.outcome    = OUT_UNMEASURABLE;
                    res.next_level = start_level;
                    o_unmeasurable++;
                end else begin
                    res.outcome    = OUT_RETRY;
                    power_level    = power_level - 1'b1;
                    res.next_level = power_level;
                    o_retries++;
                end
            end else begin
                res.outcome    = OUT_MEASURED;
                res.next_level = start_level;
                res.mode_value = best_value;
                res.mode_count = best_count;
                scaled         = window_count * best_value;
                res.integral   = {1'b0, window_sum} - scaled;
            end
            expected_results.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_waveform_result got;
        t_waveform_result want;
        if (!i_rst_n) begin
            clip_threshold  = CLIP_THRESHOLD_RST;
            window_low      = WINDOW_LOW_RST;
            window_high     = WINDOW_HIGH_RST;
            integrate_start = INTEGRATE_START_RST;
            start_level     = START_LEVEL_RST;
            power_level     = START_LEVEL_RST;
            clear_waveform();
            expected_results.delete();
            o_failures     = 0;
            o_samples      = 0;
            o_results      = 0;
            o_retries      = 0;
            o_unmeasurable = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CLIP_THRESHOLD:  clip_threshold  = i_cfg_data;
                    CFG_WINDOW_LOW:      window_low      = i_cfg_data;
                    CFG_WINDOW_HIGH:     window_high     = i_cfg_data;
                    CFG_INTEGRATE_START: integrate_start = i_cfg_data;
                    CFG_START_LEVEL:     start_level     = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                absorb_sample(i_s_axis_tdata, i_s_axis_tuser[0], i_s_axis_tlast,
                              i_s_axis_tuser[1]);
                o_samples++;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (expected_results.size() == 0) begin
                    report_mismatch("arrived with no waveform pending, outcome",
                                    got.outcome, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.outcome !== want.outcome)
                        report_mismatch("outcome", got.outcome, want.outcome);
                    if (got.level_used !== want.level_used)
                        report_mismatch("level_used", got.level_used, want.level_used);
                    if (got.next_level !== want.next_level)
                        report_mismatch("next_level", got.next_level, want.next_level);
                    if (got.mode_value !== want.mode_value)
                        report_mismatch("mode_value", got.mode_value, want.mode_value);
                    if (got.mode_count !== want.mode_count)
                        report_mismatch("mode_count", got.mode_count, want.mode_count);
                    if (got.integral !== want.integral)
                        report_mismatch("integral", longint'(got.integral),
                                        longint'(want.integral));
                end
                o_results++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/waveform_autorange_baseline_integrator_unit_test.sv =====
`timescale 1ns / 100ps

module waveform_autorange_baseline_integrator_unit_test;
    import wabi_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 16;

    typedef enum {FRAME_WHOLE, FRAME_NO_FIRST, FRAME_NO_LAST} t_framing;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [FIELD_W-1:0]     s_axis_tdata;
    logic                   s_axis_tlast;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_W-1:0]       m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]     cfg_data;

    int failures;
    int pending;
    int samples_taken;
    int results_seen;
    int retries;
    int unmeasurable;

    int                 send_idle_pct;
    int                 stall_pct;
    logic               hold_off;
    logic               bright_well;
    int                 setting_count;
    logic [FIELD_W-1:0] clip_now;
    logic [FIELD_W-1:0] low_now;
    logic [FIELD_W-1:0] high_now;

    waveform_autorange_baseline_integrator_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    waveform_result_checker result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_samples       (samples_taken),
        .o_results       (results_seen),
        .o_retries       (retries),
        .o_unmeasurable  (unmeasurable)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // one sample transaction; called and returns at a falling edge
    task automatic send_item(input logic [FIELD_W-1:0] smp, input logic first,
                             input logic last, input logic well);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        s_axis_tuser  <= {well, first};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // let trailing samples that carry no result work through too
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [FIELD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [FIELD_W-1:0] clip, input logic [FIELD_W-1:0] low,
                                  input logic [FIELD_W-1:0] high,
                                  input logic [FIELD_W-1:0] istart,
                                  input logic [LEVEL_W-1:0] level);
        drain_results();
        write_register(CFG_CLIP_THRESHOLD, clip);
        write_register(CFG_WINDOW_LOW, low);
        write_register(CFG_WINDOW_HIGH, high);
        write_register(CFG_INTEGRATE_START, istart);
        write_register(CFG_START_LEVEL, {{(FIELD_W-LEVEL_W){1'b0}}, level});
        clip_now = clip;
        low_now  = low;
        high_now = high;
        setting_count++;
    endtask

    task automatic pick_settings(input bit empty_window);
        logic [FIELD_W-1:0] low;
        logic [FIELD_W-1:0] high;
        logic [FIELD_W-1:0] istart;
        low    = FIELD_W'($urandom_range(40000));
        high   = empty_window ? low : FIELD_W'(low + $urandom_range(1, 25535));
        istart = ($urandom_range(1) == 0) ? '0 : FIELD_W'($urandom_range(1, 20));
        apply_settings(FIELD_W'($urandom_range(3000)), low, high, istart,
                       LEVEL_W'($urandom_range(3)));
    endtask

    function automatic logic [FIELD_W-1:0] in_window_value();
        if (high_now > low_now)
            return FIELD_W'(low_now + $urandom_range(high_now - low_now - 1));
        return FIELD_W'($urandom);
    endfunction

    // mostly framed waveforms built from a few repeated values, some broken framing
    task automatic run_random_phase(input int budget, input int idle_pct, input int stall,
                                    input bit squeeze);
        logic [FIELD_W-1:0] palette [4];
        logic [FIELD_W-1:0] smp;
        t_framing           framing;
        int                 sent;
        int                 len;
        int                 clip_at;
        int                 pick;
        logic               well;
        logic               clip_it;
        logic               first;
        logic               last;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        if (squeeze) begin
            fork
                begin
                    hold_off = 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_off = 1'b0;
                end
            join_none
        end
        sent = 0;
        while (sent < budget) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            well = ($urandom_range(99) < 30);
            if (well)
                bright_well = ($urandom_range(99) < 40);
            clip_it = bright_well ? ($urandom_range(99) < 80) : ($urandom_range(99) < 10);
            clip_at = $urandom_range(len - 1);
            pick    = $urandom_range(99);
            framing = (pick < 86) ? FRAME_WHOLE : (pick < 93) ? FRAME_NO_FIRST : FRAME_NO_LAST;
            foreach (palette[p]) begin
                palette[p] = in_window_value();
                if (palette[p] < clip_now)
                    palette[p] = FIELD_W'(clip_now + $urandom_range(999));
            end
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(99);
                if (pick < 55)
                    smp = palette[$urandom_range(3)];
                else if (pick < 80)
                    smp = FIELD_W'($urandom);
                else
                    smp = in_window_value();
                if (clip_it && k == clip_at && clip_now != '0)
                    smp = FIELD_W'($urandom_range(clip_now - 1));
                first = (k == 0) && (framing != FRAME_NO_FIRST);
                last  = (k == len - 1) && (framing != FRAME_NO_LAST);
                send_item(smp, first, last, first ? well : ($urandom_range(9) == 0));
            end
            sent += len;
        end
        // close with a framed result so the phase ends quiet
        send_item(palette[0], 1'b1, 1'b1, 1'b0);
    endtask

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_CLIP_THRESHOLD;
        cfg_data      = '0;
        hold_off      = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        bright_well   = 1'b0;
        setting_count = 0;
        clip_now      = CLIP_THRESHOLD_RST;
        low_now       = WINDOW_LOW_RST;
        high_now      = WINDOW_HIGH_RST;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // defaults after reset: a sample with no frame start, clipping down the levels
        send_item(16'd20000, 1'b0, 1'b1, 1'b0);
        send_item(16'd0, 1'b1, 1'b1, 1'b1);
        send_item(16'd511, 1'b1, 1'b1, 1'b0);
        send_item(16'd512, 1'b1, 1'b1, 1'b0);
        send_item(16'd65535, 1'b1, 1'b1, 1'b0);
        // tie between window edges; new_well mid-frame is ignored
        send_item(16'd10000, 1'b1, 1'b0, 1'b0);
        send_item(16'd49999, 1'b0, 1'b0, 1'b1);
        send_item(16'd49999, 1'b0, 1'b0, 1'b0);
        send_item(16'd10000, 1'b0, 1'b0, 1'b0);
        send_item(16'd50000, 1'b0, 1'b0, 1'b0);
        send_item(16'd9999, 1'b0, 1'b1, 1'b0);
        // walk down to the lowest level, clip there, then a new well
        send_item(16'd100, 1'b1, 1'b1, 1'b0);
        send_item(16'd100, 1'b1, 1'b1, 1'b0);
        send_item(16'd100, 1'b1, 1'b1, 1'b1);

        // widest window, no clipping, lowest start level
        apply_settings('0, '0, 16'hFFFF, '0, 2'd0);
        send_item(16'd0, 1'b1, 1'b1, 1'b1);
        send_item(16'd65534, 1'b1, 1'b0, 1'b0);
        send_item(16'd0, 1'b0, 1'b0, 1'b0);
        send_item(16'd0, 1'b0, 1'b0, 1'b0);
        send_item(16'd0, 1'b0, 1'b1, 1'b0);

        // inverted window, clip almost everything, integrate from the far end
        apply_settings(16'hFFFF, 16'hFFFF, '0, 16'hFFFF, 2'd3);
        send_item(16'd65535, 1'b1, 1'b1, 1'b1);
        send_item(16'd65534, 1'b1, 1'b1, 1'b0);
        run_random_phase(60, 0, 0, 1'b0);

        pick_settings(1'b0);
        run_random_phase(300, 0, 0, 1'b1);
        pick_settings(1'b0);
        run_random_phase(350, 56, 0, 1'b0);
        pick_settings(1'b0);
        run_random_phase(350, 0, 56, 1'b0);
        pick_settings(1'b0);
        run_random_phase(350, 22, 22, 1'b0);
        pick_settings(1'b1);
        run_random_phase(150, 0, 0, 1'b0);
        pick_settings(1'b0);
        run_random_phase(300, 0, 0, 1'b0);

        drain_results();
        $display("Run covered %0d samples and %0d results (%0d retries, %0d unmeasurable)",
                 samples_taken, results_seen, retries, unmeasurable);
        $display("across %0d register settings, broken framing and a long output hold-off",
                 setting_count + 1);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
